FILE: src/aabb_overlap_row_mask_macros.svh
// Assertion macros for the block's modules.
// Depends on nothing; included by files that carry assertions.
`ifndef AABB_OVERLAP_ROW_MASK_MACROS_SVH
`define AABB_OVERLAP_ROW_MASK_MACROS_SVH

// Property checked on every clock edge when reset is released.
`define AORM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every clock edge, including during reset.
`define AORM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/aorm_pkg.sv
// Package for the box overlap block: sizes, codes and the float compare.
// Depends on nothing; used by every module of the block.
package aorm_pkg;

    localparam int SLOTS_DEF = 8;
    localparam int MASK_BITS = 8;
    localparam int SLOT_W    = 3;
    localparam int FP_W      = 32;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    typedef struct packed {
        logic [FP_W-1:0] x_min;
        logic [FP_W-1:0] y_min;
        logic [FP_W-1:0] z_min;
        logic [FP_W-1:0] x_max;
        logic [FP_W-1:0] y_max;
        logic [FP_W-1:0] z_max;
    } t_box;

    function automatic logic is_nan(input logic [FP_W-1:0] b);
        return (b[FP_W-2:0] > 31'h7f80_0000);
    endfunction

    // Monotonic key of a non-NaN float; both zeros give the same key.
    function automatic logic [FP_W-1:0] order_key(input logic [FP_W-1:0] b);
        logic [FP_W-1:0] mag;
        mag = {1'b0, b[FP_W-2:0]};
        return b[FP_W-1] ? (32'h8000_0000 - mag) : (32'h8000_0000 + mag);
    endfunction

    // Ordered a >= b: false when either operand is NaN.
    function automatic logic ge_ordered(input logic [FP_W-1:0] a,
                                        input logic [FP_W-1:0] b);
        return !is_nan(a) && !is_nan(b) && (order_key(a) >= order_key(b));
    endfunction

endpackage

FILE: src/aabb_overlap_row_mask.sv
// Top level of the box overlap block: input register, stored boxes, compare lanes,
// result register. Depends on aorm_pkg, aorm_box_store, aorm_lane_cmp and the macros.
//
// The block keeps SLOTS boxes and compares a streamed test box against all of them
// at once, one transaction per cycle unless a held test stalls. A load transaction
// (s_axis_tuser = 0) writes a box into slot s_axis_tdata[2:0] and gives no result;
// loads to slots at or above SLOTS are dropped. A test transaction gives one 8-bit
// mask: it is held in the input register, then its ordered float compares (six per
// lane, 48 with eight slots) settle into the result register. Only slots 0 to 7 appear
// in the mask. Results of a test against a slot that was never loaded are undefined.
`include "aabb_overlap_row_mask_macros.svh"

module aabb_overlap_row_mask #(
    parameter int SLOTS = aorm_pkg::SLOTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // slot[2:0], x_min[34:3], y_min[66:35], z_min[98:67], x_max[130:99],
    // y_max[162:131], z_max[194:163], zeros[199:195]
    input  logic [199:0] s_axis_tdata,
    // op[0]
    input  logic         s_axis_tuser,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // overlap_mask[7:0]
    output logic [7:0]   m_axis_tdata,
    output logic         m_axis_tlast
);

    localparam int LANES = (SLOTS < aorm_pkg::MASK_BITS) ? SLOTS : aorm_pkg::MASK_BITS;

    logic                        r_in_vld;
    logic                        r_in_op;
    logic [aorm_pkg::SLOT_W-1:0] r_in_slot;
    aorm_pkg::t_box              r_in_box;
    logic                        r_in_last;
    logic                        r_out_vld;
    logic [7:0]                  r_out_mask;
    logic                        r_out_last;
    logic [7:0]                  n_mask;
    logic                        out_free;
    logic                        in_adv;
    logic                        wr_en;
    aorm_pkg::t_box              boxes [SLOTS];

    // Loads never reach the output, so only a test waits for the result register.
    assign out_free      = !r_out_vld || m_axis_tready;
    assign in_adv        = !r_in_vld || (r_in_op == aorm_pkg::OP_LOAD) || out_free;
    assign s_axis_tready = in_adv;
    assign wr_en         = r_in_vld && (r_in_op == aorm_pkg::OP_LOAD)
                        && ({2'b0, r_in_slot} < 5'(SLOTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_adv) begin
            r_in_vld <= s_axis_tvalid;
        end
        if (in_adv) begin
            r_in_op   <= s_axis_tuser;
            r_in_slot <= s_axis_tdata[2:0];
            r_in_box  <= '{x_min: s_axis_tdata[34:3],    y_min: s_axis_tdata[66:35],
                           z_min: s_axis_tdata[98:67],   x_max: s_axis_tdata[130:99],
                           y_max: s_axis_tdata[162:131], z_max: s_axis_tdata[194:163]};
            r_in_last <= s_axis_tlast;
        end
    end

    aorm_box_store #(.SLOTS(SLOTS)) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_slot (r_in_slot),
        .i_wr_box  (r_in_box),
        .o_boxes   (boxes)
    );

    always_comb begin
        n_mask = '0;
        for (int j = LANES; j < 8; j++) begin
            n_mask[j] = 1'b0;
        end
    end

    logic [LANES-1:0] hits;
    for (genvar j = 0; j < LANES; j++) begin : g_lane
        aorm_lane_cmp u_lane (
            .i_test   (r_in_box),
            .i_stored (boxes[j]),
            .o_hit    (hits[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld && (r_in_op == aorm_pkg::OP_TEST);
        end
        if (out_free) begin
            r_out_mask <= n_mask | 8'(hits);
            r_out_last <= r_in_last;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_mask;
    assign m_axis_tlast  = r_out_last;

    `AORM_ASSERT(a_out_hold, i_clk, i_rst_n, r_out_vld && !m_axis_tready |=> r_out_vld && $stable(r_out_mask), "stalled result changed")
    `AORM_ASSERT(a_load_no_result, i_clk, i_rst_n, r_in_vld && r_in_op == aorm_pkg::OP_LOAD && out_free |=> !r_out_vld, "load produced a result")
    `AORM_ASSERT(a_test_result, i_clk, i_rst_n, r_in_vld && r_in_op == aorm_pkg::OP_TEST && out_free |=> r_out_vld, "test result lost")
    `AORM_ASSERT(a_in_hold, i_clk, i_rst_n, r_in_vld && !in_adv |=> r_in_vld && $stable(r_in_box), "held test item changed")

endmodule

FILE: src/aorm_box_store.sv
// Register file of stored boxes, one row per slot, each read at a fixed place.
// Depends on aorm_pkg.
module aorm_box_store #(
    parameter int SLOTS = aorm_pkg::SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [aorm_pkg::SLOT_W-1:0] i_wr_slot,
    input  aorm_pkg::t_box              i_wr_box,
    output aorm_pkg::t_box              o_boxes [SLOTS]
);

    aorm_pkg::t_box r_boxes [SLOTS];

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < SLOTS; s++) begin
            if (i_wr_en && ({2'b0, i_wr_slot} == 5'(s))) begin
                r_boxes[s] <= i_wr_box;
            end
        end
    end

    assign o_boxes = r_boxes;

endmodule

FILE: src/aorm_lane_cmp.sv
// One overlap lane: six ordered float compares of a tested box against a stored box.
// Depends on aorm_pkg.
module aorm_lane_cmp (
    input  aorm_pkg::t_box i_test,
    input  aorm_pkg::t_box i_stored,
    output logic           o_hit
);

    assign o_hit = aorm_pkg::ge_ordered(i_test.x_max, i_stored.x_min)
                && aorm_pkg::ge_ordered(i_test.y_max, i_stored.y_min)
                && aorm_pkg::ge_ordered(i_test.z_max, i_stored.z_min)
                && aorm_pkg::ge_ordered(i_stored.x_max, i_test.x_min)
                && aorm_pkg::ge_ordered(i_stored.y_max, i_test.y_min)
                && aorm_pkg::ge_ordered(i_stored.z_max, i_test.z_min);

endmodule
